### rtl/cbsd_pkg.sv
// Shared types and constants for the camera block stream deframer.
`timescale 1ns / 1ps

package cbsd_pkg;

    localparam int MAX_BLOCKS = 32;
    localparam logic [5:0] LIMIT_RESET = 6'd32;

    localparam logic [7:0] BYTE_00 = 8'h00;
    localparam logic [7:0] BYTE_55 = 8'h55;
    localparam logic [7:0] BYTE_56 = 8'h56;
    localparam logic [7:0] BYTE_AA = 8'haa;

    typedef enum logic [1:0] {
        MODE_HUNT   = 2'd0,
        MODE_CSUM   = 2'd1,
        MODE_FIELDS = 2'd2,
        MODE_SEP    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_GOOD = 2'd0,
        KIND_BAD  = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_00;
        logic       is_55;
        logic       is_56;
        logic       is_aa;
    } token_t;

    typedef struct packed {
        logic zero;
        logic normal;
        logic code;
    } word_class_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] signature;
        logic [15:0] x_center;
        logic [15:0] y_center;
        logic [15:0] box_width;
        logic [15:0] box_height;
        logic [15:0] angle;
        logic        color_code;
        logic [4:0]  block_index;
        logic [5:0]  frame_blocks;
    } result_t;

    localparam int TOKEN_W  = $bits(token_t);
    localparam int RESULT_W = $bits(result_t);

endpackage

### rtl/cbsd_fifo.sv
// Small register queue used between the deframer stages and at the result side.
`timescale 1ns / 1ps

module cbsd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/cbsd_front.sv
// Front stage: accepts received bytes and tags the ones that make up sync words.
`timescale 1ns / 1ps

module cbsd_front
    import cbsd_pkg::*;
(
    input  logic       push,
    input  logic [7:0] rx_byte,
    input  logic       queue_full,
    output logic       full,
    output logic       tok_push,
    output token_t     tok
);

    assign full     = queue_full;
    assign tok_push = push && !queue_full;

    always_comb
    begin
        tok.data  = rx_byte;
        tok.is_00 = (rx_byte == BYTE_00);
        tok.is_55 = (rx_byte == BYTE_55);
        tok.is_56 = (rx_byte == BYTE_56);
        tok.is_aa = (rx_byte == BYTE_AA);
    end

endmodule

### rtl/cbsd_back.sv
// Back stage: pairs bytes into words, tracks framing and builds block results.
`timescale 1ns / 1ps

module cbsd_back
    import cbsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data,
    input  logic       tok_valid,
    input  token_t     tok,
    output logic       tok_pop,
    input  logic       res_full,
    output logic       res_push,
    output result_t    res
);

    logic        phase_reg, phase_next;
    token_t      low_reg, low_next;
    logic        skip_reg, skip_next;
    word_class_t prev_reg, prev_next;
    mode_t       mode_reg, mode_next;
    logic [2:0]  idx_reg, idx_next;
    logic        code_reg, code_next;
    logic [15:0] csum_reg, csum_next;
    logic [18:0] sum_reg, sum_next;
    logic [5:0]  good_reg, good_next;
    logic [5:0]  limit_reg;
    logic [15:0] store_reg [5];

    logic        step;
    logic [15:0] word;
    word_class_t wcls;
    logic        w_swapped;
    logic        w_start;
    logic [18:0] sum_new;
    logic [5:0]  limit_eff;
    logic        store_we;
    logic        emit_end;
    logic        emit_block;
    logic        block_ok;
    logic [5:0]  end_count;

    assign step     = tok_valid && !res_full;
    assign tok_pop  = step;
    assign res_push = emit_end || emit_block;

    assign word        = {tok.data, low_reg.data};
    assign wcls.zero   = low_reg.is_00 && tok.is_00;
    assign wcls.normal = low_reg.is_55 && tok.is_aa;
    assign wcls.code   = low_reg.is_56 && tok.is_aa;
    assign w_swapped   = low_reg.is_aa && tok.is_55;
    assign w_start     = wcls.normal || wcls.code;
    assign sum_new     = sum_reg + {3'b000, word};
    assign block_ok    = (sum_new == {3'b000, csum_reg});

    always_comb
    begin
        if (limit_reg == 6'd0)
        begin
            limit_eff = 6'd1;
        end
        else if (limit_reg > 6'(MAX_BLOCKS))
        begin
            limit_eff = 6'(MAX_BLOCKS);
        end
        else
        begin
            limit_eff = limit_reg;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        low_next   = low_reg;
        skip_next  = skip_reg;
        prev_next  = prev_reg;
        mode_next  = mode_reg;
        idx_next   = idx_reg;
        code_next  = code_reg;
        csum_next  = csum_reg;
        sum_next   = sum_reg;
        good_next  = good_reg;
        store_we   = 1'b0;
        emit_end   = 1'b0;
        emit_block = 1'b0;
        end_count  = good_reg;
        if (step)
        begin
            if (!phase_reg)
            begin
                if (skip_reg)
                begin
                    skip_next = 1'b0;
                end
                else
                begin
                    low_next   = tok;
                    phase_next = 1'b1;
                end
            end
            else
            begin
                phase_next = 1'b0;
                unique case (mode_reg)
                    MODE_HUNT:
                    begin
                        if (wcls.zero && prev_reg.zero)
                        begin
                            good_next = '0;
                            end_count = '0;
                            emit_end  = 1'b1;
                            prev_next = '0;
                        end
                        else if (wcls.normal && prev_reg.normal)
                        begin
                            code_next = 1'b0;
                            mode_next = MODE_CSUM;
                            good_next = '0;
                        end
                        else if (wcls.code && prev_reg.code)
                        begin
                            code_next = 1'b1;
                            mode_next = MODE_CSUM;
                            good_next = '0;
                        end
                        else
                        begin
                            if (w_swapped)
                            begin
                                skip_next = 1'b1;
                            end
                            prev_next = wcls;
                        end
                    end
                    MODE_CSUM:
                    begin
                        if (w_start)
                        begin
                            code_next = wcls.code;
                            emit_end  = 1'b1;
                            good_next = '0;
                        end
                        else if (wcls.zero)
                        begin
                            emit_end  = 1'b1;
                            mode_next = MODE_HUNT;
                            prev_next = '0;
                        end
                        else
                        begin
                            csum_next = word;
                            sum_next  = '0;
                            idx_next  = '0;
                            mode_next = MODE_FIELDS;
                        end
                    end
                    MODE_FIELDS:
                    begin
                        sum_next = sum_new;
                        store_we = (idx_reg < 3'd5);
                        if ((idx_reg >= 3'd5) || (idx_reg == 3'd4 && !code_reg))
                        begin
                            emit_block = 1'b1;
                            if (block_ok)
                            begin
                                good_next = good_reg + 1'b1;
                            end
                            idx_next  = '0;
                            mode_next = MODE_SEP;
                        end
                        else
                        begin
                            idx_next = idx_reg + 1'b1;
                        end
                    end
                    MODE_SEP:
                    begin
                        if (w_start)
                        begin
                            code_next = wcls.code;
                        end
                        if (w_start && (good_reg < limit_eff))
                        begin
                            mode_next = MODE_CSUM;
                        end
                        else
                        begin
                            emit_end  = 1'b1;
                            mode_next = MODE_HUNT;
                            prev_next = '0;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_HUNT;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res = '0;
        if (emit_end)
        begin
            res.kind         = KIND_END;
            res.frame_blocks = end_count;
        end
        else
        begin
            res.kind        = block_ok ? KIND_GOOD : KIND_BAD;
            res.signature   = store_reg[0];
            res.x_center    = store_reg[1];
            res.y_center    = store_reg[2];
            res.box_width   = store_reg[3];
            res.box_height  = code_reg ? store_reg[4] : word;
            res.angle       = code_reg ? word : 16'd0;
            res.color_code  = code_reg;
            res.block_index = block_ok ? good_reg[4:0] : 5'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            low_reg   <= '0;
            skip_reg  <= 1'b0;
            prev_reg  <= '0;
            mode_reg  <= MODE_HUNT;
            idx_reg   <= '0;
            code_reg  <= 1'b0;
            csum_reg  <= '0;
            sum_reg   <= '0;
            good_reg  <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            phase_reg <= phase_next;
            low_reg   <= low_next;
            skip_reg  <= skip_next;
            prev_reg  <= prev_next;
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            code_reg  <= code_next;
            csum_reg  <= csum_next;
            sum_reg   <= sum_next;
            good_reg  <= good_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[idx_reg] <= word;
        end
    end

endmodule

### rtl/camera_block_stream_deframer.sv
// Top level of the camera block stream deframer.
//
//  Channel   Direction  Handshake                      Payload
//  input     in         push / full                    rx_byte
//  result    out        empty / pop                    result_kind .. frame_blocks
//  config    in         cfg_wr_en (no wait)            cfg_wr_data (block limit)
//
// Takes one byte per cycle sustained; the back stage handles one byte per cycle
// unless the result queue is full. Results show on the result ports from that queue.
// Reset clears all framing state, empties both queues and sets the limit to 32.
// While pop stays low, the two-entry result queue fills, the back stage holds,
// the two-entry byte queue fills and full rises.
`timescale 1ns / 1ps

module camera_block_stream_deframer
    import cbsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic [7:0]  rx_byte,
    output logic        full,
    input  logic        cfg_wr_en,
    input  logic [5:0]  cfg_wr_data,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  result_kind,
    output logic [15:0] signature,
    output logic [15:0] x_center,
    output logic [15:0] y_center,
    output logic [15:0] box_width,
    output logic [15:0] box_height,
    output logic [15:0] angle,
    output logic        color_code,
    output logic [4:0]  block_index,
    output logic [5:0]  frame_blocks
);

    logic                tok_push;
    token_t              tok_in;
    logic [TOKEN_W-1:0]  tok_q_data;
    token_t              tok_out;
    logic                tok_q_full;
    logic                tok_q_empty;
    logic                tok_pop;
    logic                res_push;
    result_t             res_in;
    logic [RESULT_W-1:0] res_q_data;
    result_t             res_out;
    logic                res_q_full;

    cbsd_front u_front (
        .push       (push),
        .rx_byte    (rx_byte),
        .queue_full (tok_q_full),
        .full       (full),
        .tok_push   (tok_push),
        .tok        (tok_in)
    );

    cbsd_fifo #(
        .WIDTH (TOKEN_W),
        .DEPTH (2)
    ) u_tok_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tok_push),
        .wr_data (tok_in),
        .rd_en   (tok_pop),
        .rd_data (tok_q_data),
        .full    (tok_q_full),
        .empty   (tok_q_empty)
    );

    assign tok_out = token_t'(tok_q_data);

    cbsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tok_valid   (!tok_q_empty),
        .tok         (tok_out),
        .tok_pop     (tok_pop),
        .res_full    (res_q_full),
        .res_push    (res_push),
        .res         (res_in)
    );

    cbsd_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_q_data),
        .full    (res_q_full),
        .empty   (empty)
    );

    assign res_out      = result_t'(res_q_data);
    assign result_kind  = res_out.kind;
    assign signature    = res_out.signature;
    assign x_center     = res_out.x_center;
    assign y_center     = res_out.y_center;
    assign box_width    = res_out.box_width;
    assign box_height   = res_out.box_height;
    assign angle        = res_out.angle;
    assign color_code   = res_out.color_code;
    assign block_index  = res_out.block_index;
    assign frame_blocks = res_out.frame_blocks;

`ifndef SYNTHESIS
    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_END) |->
            (signature == 16'd0 && angle == 16'd0 && color_code == 1'b0
             && block_index == 5'd0))
        else $error("frame end carries block data");

    a_block_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result_kind == KIND_GOOD || result_kind == KIND_BAD)) |->
            (frame_blocks == 6'd0))
        else $error("block result carries a frame count");

    a_bad_index: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_BAD) |-> (block_index == 5'd0))
        else $error("checksum error block has an index");

    a_angle_code: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && angle != 16'd0) |-> color_code)
        else $error("angle on a normal block");
`endif

endmodule
